// File: hw/rtl/rm2q_pkg.sv
// Shared widths, types and helper functions for the rotation matrix to quaternion block.
// No dependencies; every other file of the block refers to this package by scoped names.
package rm2q_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W = 16;
	localparam int OUT_W = 16;
	// Signed numerator: difference or sum of two matrix elements.
	localparam int NUM_W = IN_W + 1;
	localparam int MAG_W = NUM_W;
	// Signed radicand, also wide enough for the trace.
	localparam int RAD_W = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 2;
	localparam int SQI_W = RAD_W - 1 + FRAC_BITS;
	localparam int SQ_W = SQI_W + (SQI_W % 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int DVD_W = MAG_W + FRAC_BITS + 1;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic signed [RAD_W-1:0] RAD_ONE =
		{{(RAD_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		COMP_W,
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	// One classified matrix: radicand magnitude, numerator magnitudes and signs.
	typedef struct packed {
		logic [RAD_W-2:0]            rad;
		logic [3:0][MAG_W-1:0]       mag;
		logic [3:0]                  neg;
		comp_t                       dom;
		logic                        degen;
	} work_t;

	typedef struct packed {
		logic                        full;
		logic                        empty;
		logic [QCNT_W-1:0]           count;
	} qstat_t;

	// Applies a sign to a magnitude and saturates to the output width.
	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [DVD_W-1:0] mag);
		logic [DVD_W-1:0] neg_mag;
		neg_mag = -mag;
		if (!neg) begin
			if (mag > DVD_W'(SAT_POS))
				return SAT_POS;
			return mag[OUT_W-1:0];
		end
		if (mag > DVD_W'(SAT_NEG))
			return SAT_NEG;
		return neg_mag[OUT_W-1:0];
	endfunction

endpackage

// File: hw/rtl/rm2q_front.sv
// Front end: computes the trace, picks the branch, forms radicand and numerators.
// Depends on rm2q_pkg; feeds rm2q_queue through a one-entry output register.
module rm2q_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m00,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m01,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m02,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m10,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m11,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m12,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m20,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m21,
	input  logic signed [rm2q_pkg::IN_W-1:0]     m22,
	output logic                                 out_valid,
	output rm2q_pkg::work_t                      out_data,
	input  logic                                 out_ready
);

	logic signed [rm2q_pkg::RAD_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [rm2q_pkg::RAD_W-1:0] trace, rad;
	logic signed [rm2q_pkg::NUM_W-1:0] n [4];
	rm2q_pkg::work_t                   cls;
	logic                              valid_s1;
	rm2q_pkg::work_t                   data_s1;
	logic                              load;

	assign e00 = rm2q_pkg::RAD_W'(m00);
	assign e01 = rm2q_pkg::RAD_W'(m01);
	assign e02 = rm2q_pkg::RAD_W'(m02);
	assign e10 = rm2q_pkg::RAD_W'(m10);
	assign e11 = rm2q_pkg::RAD_W'(m11);
	assign e12 = rm2q_pkg::RAD_W'(m12);
	assign e20 = rm2q_pkg::RAD_W'(m20);
	assign e21 = rm2q_pkg::RAD_W'(m21);
	assign e22 = rm2q_pkg::RAD_W'(m22);
	assign trace = e00 + e11 + e22;

	always_comb begin
		cls = '0;
		rad = '0;
		for (int i = 0; i < 4; i++)
			n[i] = '0;
		if (!trace[rm2q_pkg::RAD_W-1] && trace != '0) begin
			cls.dom = rm2q_pkg::COMP_W;
			rad = trace + rm2q_pkg::RAD_ONE;
			n[1] = rm2q_pkg::NUM_W'(e21 - e12);
			n[2] = rm2q_pkg::NUM_W'(e02 - e20);
			n[3] = rm2q_pkg::NUM_W'(e10 - e01);
		end else if (m00 > m11 && m00 > m22) begin
			cls.dom = rm2q_pkg::COMP_X;
			rad = rm2q_pkg::RAD_ONE + e00 - e11 - e22;
			n[0] = rm2q_pkg::NUM_W'(e21 - e12);
			n[2] = rm2q_pkg::NUM_W'(e01 + e10);
			n[3] = rm2q_pkg::NUM_W'(e02 + e20);
		end else if (m11 > m22) begin
			cls.dom = rm2q_pkg::COMP_Y;
			rad = rm2q_pkg::RAD_ONE + e11 - e00 - e22;
			n[0] = rm2q_pkg::NUM_W'(e02 - e20);
			n[1] = rm2q_pkg::NUM_W'(e01 + e10);
			n[3] = rm2q_pkg::NUM_W'(e12 + e21);
		end else begin
			cls.dom = rm2q_pkg::COMP_Z;
			rad = rm2q_pkg::RAD_ONE + e22 - e00 - e11;
			n[0] = rm2q_pkg::NUM_W'(e10 - e01);
			n[1] = rm2q_pkg::NUM_W'(e02 + e20);
			n[2] = rm2q_pkg::NUM_W'(e12 + e21);
		end
		cls.degen = rad[rm2q_pkg::RAD_W-1] || rad == '0;
		// A degenerate item still flows through the back end with a zero radicand.
		cls.rad = cls.degen ? '0 : rad[rm2q_pkg::RAD_W-2:0];
		for (int i = 0; i < 4; i++) begin
			cls.neg[i] = n[i][rm2q_pkg::NUM_W-1];
			cls.mag[i] = n[i][rm2q_pkg::NUM_W-1] ? rm2q_pkg::MAG_W'(-n[i])
				: rm2q_pkg::MAG_W'(n[i]);
		end
	end

	assign full = valid_s1 && !out_ready;
	assign load = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!full)
			valid_s1 <= push;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_s1 <= cls;
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;

endmodule

// File: hw/rtl/rm2q_queue.sv
// Short queue between the front end and the back end so that each side stalls on its own.
// Depends on rm2q_pkg for the item type and depth.
module rm2q_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rm2q_pkg::work_t  in_data,
	output logic             in_ready,
	output logic             out_valid,
	output rm2q_pkg::work_t  out_data,
	input  logic             out_ready,
	output rm2q_pkg::qstat_t stat
);

	rm2q_pkg::work_t                mem_q [rm2q_pkg::QDEPTH];
	logic [rm2q_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
	logic [rm2q_pkg::QCNT_W-1:0]    count_q;
	logic                           wr, rd;

	assign in_ready = count_q != rm2q_pkg::QCNT_W'(rm2q_pkg::QDEPTH);
	assign out_valid = count_q != '0;
	assign out_data = mem_q[rptr_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	assign stat.full = !in_ready;
	assign stat.empty = !out_valid;
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == rm2q_pkg::QPTR_W'(rm2q_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == rm2q_pkg::QPTR_W'(rm2q_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= in_data;
	end

endmodule

// File: hw/rtl/rm2q_back.sv
// Back end: pipelined square root (one root bit per stage), then four pipelined
// restoring dividers (one quotient bit per stage), then sign, saturation and output register.
// Depends on rm2q_pkg.
module rm2q_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  rm2q_pkg::work_t                    in_data,
	output logic                               in_ready,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_w,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_x,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_y,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_z,
	output logic                               degenerate,
	output logic                               empty,
	input  logic                               pop
);

	localparam int RT = rm2q_pkg::ROOT_W;
	localparam int DW = rm2q_pkg::DVD_W;

	logic adv;

	// Square root stages.
	logic                          sq_v    [RT+1];
	logic [rm2q_pkg::SQ_W-1:0]     sq_x    [RT+1];
	logic [RT:0]                   sq_rem  [RT+1];
	logic [RT-1:0]                 sq_root [RT+1];
	rm2q_pkg::work_t               sq_info [RT+1];

	// Divider stages; the dividend register fills with quotient bits from the bottom.
	logic                          dv_v    [DW+1];
	logic [3:0][DW-1:0]            dv_x    [DW+1];
	logic [3:0][RT:0]              dv_rem  [DW+1];
	logic [RT-1:0]                 dv_root [DW+1];
	rm2q_pkg::work_t               dv_info [DW+1];

	logic                          out_v_q;
	logic [rm2q_pkg::OUT_W-1:0]    res [4];
	logic [RT:0]                   half_root;

	assign adv = !out_v_q || pop;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v[0] <= 1'b0;
		else if (adv)
			sq_v[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x[0] <= rm2q_pkg::SQ_W'({in_data.rad, {rm2q_pkg::FRAC_BITS{1'b0}}});
			sq_rem[0] <= '0;
			sq_root[0] <= '0;
			sq_info[0] <= in_data;
		end
	end

	for (genvar k = 0; k < RT; k++) begin : g_sqrt
		logic [RT+2:0] rem_n;
		logic [RT+2:0] trial;
		logic          take;

		assign rem_n = {sq_rem[k], sq_x[k][rm2q_pkg::SQ_W-1 -: 2]};
		assign trial = {1'b0, sq_root[k], 2'b01};
		assign take = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[k+1] <= 1'b0;
			else if (adv)
				sq_v[k+1] <= sq_v[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_x[k+1] <= sq_x[k] << 2;
				sq_rem[k+1] <= take ? (RT+1)'(rem_n - trial) : (RT+1)'(rem_n);
				sq_root[k+1] <= {sq_root[k][RT-2:0], take};
				sq_info[k+1] <= sq_info[k];
			end
		end
	end

	// Dividend is numerator << FRAC_BITS plus root, which rounds to nearest over 2 * root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (adv)
			dv_v[0] <= sq_v[RT];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				dv_x[0][c] <= DW'({sq_info[RT].mag[c], {rm2q_pkg::FRAC_BITS{1'b0}}})
					+ DW'(sq_root[RT]);
				dv_rem[0][c] <= '0;
			end
			dv_root[0] <= sq_root[RT];
			dv_info[0] <= sq_info[RT];
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [RT+1:0] den;
		logic [RT+1:0] rn   [4];
		logic          take [4];

		assign den = {1'b0, dv_root[k], 1'b0};
		for (genvar c = 0; c < 4; c++) begin : g_lane
			assign rn[c] = {dv_rem[k][c], dv_x[k][c][DW-1]};
			assign take[c] = rn[c] >= den;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[k+1] <= 1'b0;
			else if (adv)
				dv_v[k+1] <= dv_v[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < 4; c++) begin
					dv_rem[k+1][c] <= take[c] ? (RT+1)'(rn[c] - den) : (RT+1)'(rn[c]);
					dv_x[k+1][c] <= {dv_x[k][c][DW-2:0], take[c]};
				end
				dv_root[k+1] <= dv_root[k];
				dv_info[k+1] <= dv_info[k];
			end
		end
	end

	// The dominant component is half the root, rounded up.
	assign half_root = ({1'b0, dv_root[DW]} + 1'b1) >> 1;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (dv_info[DW].degen)
				res[c] = '0;
			else if (rm2q_pkg::comp_t'(c) == dv_info[DW].dom)
				res[c] = rm2q_pkg::sat_out(1'b0, DW'(half_root));
			else
				res[c] = rm2q_pkg::sat_out(dv_info[DW].neg[c], dv_x[DW][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= dv_v[DW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_w <= res[0];
			q_x <= res[1];
			q_y <= res[2];
			q_z <= res[3];
			degenerate <= dv_info[DW].degen;
		end
	end

	assign empty = !out_v_q;

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q1.14) to unit quaternion, Shepperd's method, fully pipelined.
// Path from the input transfer to the ports: front-end register, queue write, square root
// input register and 16 stages, divider input register and 32 stages, output register.
// Throughput: one item per cycle while results are popped. The divider chain is longest.
// Reset (arst_n low, asynchronous) empties the queue and every pipeline stage.
module rotation_matrix_to_quaternion (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m00,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m01,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m02,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m10,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m11,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m12,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m20,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m21,
	input  logic signed [rm2q_pkg::IN_W-1:0]   m22,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_w,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_x,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_y,
	output logic signed [rm2q_pkg::OUT_W-1:0]  q_z,
	output logic                               degenerate
);

	logic             fr_valid, fr_ready;
	rm2q_pkg::work_t  fr_data;
	logic             bk_valid, bk_ready;
	rm2q_pkg::work_t  bk_data;
	rm2q_pkg::qstat_t q_stat;

	rm2q_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.m00       (m00),
		.m01       (m01),
		.m02       (m02),
		.m10       (m10),
		.m11       (m11),
		.m12       (m12),
		.m20       (m20),
		.m21       (m21),
		.m22       (m22),
		.out_valid (fr_valid),
		.out_data  (fr_data),
		.out_ready (fr_ready)
	);

	rm2q_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_data   (fr_data),
		.in_ready  (fr_ready),
		.out_valid (bk_valid),
		.out_data  (bk_data),
		.out_ready (bk_ready),
		.stat      (q_stat)
	);

	rm2q_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (bk_valid),
		.in_data    (bk_data),
		.in_ready   (bk_ready),
		.q_w        (q_w),
		.q_x        (q_x),
		.q_y        (q_y),
		.q_z        (q_z),
		.degenerate (degenerate),
		.empty      (empty),
		.pop        (pop)
	);

	// A degenerate result carries all-zero components.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> (q_w == '0 && q_x == '0 && q_y == '0 && q_z == '0))
		else $error("degenerate result with nonzero components");

	// The queue count never exceeds its depth and agrees with its flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count <= rm2q_pkg::QCNT_W'(rm2q_pkg::QDEPTH))
		&& (q_stat.empty == (q_stat.count == '0)))
		else $error("queue count out of range");

	// The front end only stalls when the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_stat.full)
		else $error("front end stalled with room in the queue");

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_chk.sv
// Checker for the rotation matrix to quaternion block: watches both queue-style ports,
// predicts each quaternion from the accepted matrix and compares. Depends on rm2q_pkg.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	input  logic        empty,
	input  logic        pop,
	input  logic [15:0] q_w, q_x, q_y, q_z,
	input  logic        degenerate,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [15:0] w, x, y, z;
		logic        degen;
	} quat_t;

	quat_t quat_q[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Division of a numerator scaled by one, rounded to nearest with ties away from zero.
	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag, qv;
		mag = (num < 0) ? longint'(-num) : num;
		qv = ((mag << rm2q_pkg::FRAC_BITS) + (den >> 1)) / den;
		return (num < 0) ? -longint'(qv) : longint'(qv);
	endfunction

	function automatic quat_t convert(logic signed [15:0] e [9]);
		longint a [9];
		longint one, tr, rad, num [4];
		longint unsigned root;
		longint res [4];
		rm2q_pkg::comp_t dom;
		quat_t r;
		for (int i = 0; i < 9; i++) a[i] = e[i];
		one = 64'sd1 << rm2q_pkg::FRAC_BITS;
		tr = a[0] + a[4] + a[8];
		if (tr > 0) begin
			dom = rm2q_pkg::COMP_W;
			rad = tr + one;
			num[1] = a[7] - a[5]; num[2] = a[2] - a[6]; num[3] = a[3] - a[1];
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			dom = rm2q_pkg::COMP_X;
			rad = one + a[0] - a[4] - a[8];
			num[0] = a[7] - a[5]; num[2] = a[1] + a[3]; num[3] = a[2] + a[6];
		end else if (a[4] > a[8]) begin
			dom = rm2q_pkg::COMP_Y;
			rad = one + a[4] - a[0] - a[8];
			num[0] = a[2] - a[6]; num[1] = a[1] + a[3]; num[3] = a[5] + a[7];
		end else begin
			dom = rm2q_pkg::COMP_Z;
			rad = one + a[8] - a[0] - a[4];
			num[0] = a[3] - a[1]; num[1] = a[2] + a[6]; num[2] = a[5] + a[7];
		end
		for (int i = 0; i < 4; i++) res[i] = 0;
		r.degen = (rad <= 0);
		if (!r.degen) begin
			root = int_sqrt(longint'(rad) << rm2q_pkg::FRAC_BITS);
			for (int i = 0; i < 4; i++)
				res[i] = (i == int'(dom)) ? clamp16(longint'((root + 1) >> 1))
					: clamp16(round_div(num[i], root << 1));
		end
		r.w = 16'(res[0]); r.x = 16'(res[1]); r.y = 16'(res[2]); r.z = 16'(res[3]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] e [9];
		quat_t got, want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (push && !full) begin
				e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
				quat_q.push_back(convert(e));
			end
			if (pop && !empty) begin
				got = '{q_w, q_x, q_y, q_z, degenerate};
				if (quat_q.size() == 0) begin
					if (errors < 10) $display("unexpected result transfer %p", got);
					errors <= errors + 1;
				end else begin
					want = quat_q.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch: expected w=%h x=%h y=%h z=%h d=%b, got w=%h x=%h y=%h z=%h d=%b",
								want.w, want.x, want.y, want.z, want.degen,
								got.w, got.x, got.y, got.z, got.degen);
						errors <= errors + 1;
					end
				end
			end
			pending <= quat_q.size();
		end
	end

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_tb.sv
// Top of the rotation matrix to quaternion testbench: clock, reset, matrix stimulus,
// result draining and the verdict. Depends on rm2q_pkg, the block and its checker.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

	localparam int LATENCY = 53;
	localparam int WATCHDOG = 5000;

	logic clk, arst_n, push, full, empty, pop, degenerate;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [15:0] q_w, q_x, q_y, q_z;
	int errors, pending, idle_cycles;
	bit quiet, hold;

	rotation_matrix_to_quaternion dut (.*);
	rotation_matrix_to_quaternion_chk chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver: random stalls, plus a long hold-off while the sender keeps offering items.
	always @(posedge clk) begin
		if (!arst_n) pop <= 0;
		else pop <= !hold && (quiet || $urandom_range(99) >= 23);
	end

	initial begin
		hold = 0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		hold = 1;
		repeat (300) @(posedge clk);
		hold = 0;
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("rotation_matrix_to_quaternion_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h4000;
			3: return 16'hc000;
			4: return 16'($urandom_range(16'h1000) - 16'h0800);
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends one matrix, holding it until the transfer takes place.
	task automatic send(input logic [15:0] e [9]);
		push <= 1;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		do @(posedge clk); while (full);
		if (!quiet && $urandom_range(99) < 23) begin
			push <= 0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
	endtask

	// Builds a matrix in the pattern of a rotation about one axis, with the cosine and sine taken freely.
	task automatic make_rotation(output logic [15:0] e [9]);
		logic signed [15:0] c, s;
		int axis;
		c = 16'($urandom_range(32768) - 16384);
		s = 16'($urandom_range(32768) - 16384);
		axis = $urandom_range(2);
		foreach (e[i]) e[i] = 0;
		case (axis)
			0: e = '{16'h4000, 0, 0, 0, c, -s, 0, s, c};
			1: e = '{c, 0, s, 0, 16'h4000, 0, -s, 0, c};
			default: e = '{c, -s, 0, s, c, 0, 0, 0, 16'h4000};
		endcase
	endtask

	initial begin
		logic [15:0] e [9];
		push = 0;
		quiet = 0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		@(posedge clk);
		wait (arst_n);
		@(posedge clk);
		// Identity, half turns about each axis, all extremes, zero and further edge-case matrices.
		e = '{16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'h4000}; send(e);
		e = '{16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'hc000}; send(e);
		e = '{16'hc000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'hc000}; send(e);
		e = '{16'hc000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'h4000}; send(e);
		foreach (e[i]) e[i] = 16'h7fff; send(e);
		foreach (e[i]) e[i] = 16'h8000; send(e);
		foreach (e[i]) e[i] = 0; send(e);
		e = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000}; send(e);
		e = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hc000, 16'h8000, 16'h7fff,
			16'h8000, 16'hc000}; send(e);
		e = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000}; send(e);
		e = '{0, 16'h7fff, 16'h8000, 16'h8000, 0, 16'h7fff, 16'h7fff, 16'h8000, 1}; send(e);
		e = '{16'hffff, 0, 0, 0, 16'hffff, 0, 0, 0, 16'h0002}; send(e);
		for (int n = 0; n < 1600; n++) begin
			quiet = (n >= 800 && n < 1000);
			if ($urandom_range(99) < 60) make_rotation(e);
			else foreach (e[i]) e[i] = pick_value();
			send(e);
		end
		push <= 0;
		quiet = 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) $display("rotation_matrix_to_quaternion_tb: done, clean");
		else $display("rotation_matrix_to_quaternion_tb: done, errors");
		$finish;
	end

endmodule
